>>> rtl/core/sdsh_pkg.sv
// ----------------------------------------------------------------------------
// sdsh_pkg
// Types and constants for the SD card SPI-mode host sequencer.
// ----------------------------------------------------------------------------
package sdsh_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sector;
        logic [7:0]  block_count;
        logic [7:0]  rx_byte;
    } sdsh_in_t;

    typedef struct packed {
        logic        exchange_request;
        logic [7:0]  tx_byte;
        logic        select_high;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        last;
        logic        done_res;
        logic [1:0]  status;
        logic        block_addressing;
    } sdsh_out_t;

    localparam logic [1:0] KIND_INIT = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_XFER = 2'd2;
    localparam logic [1:0] KIND_NOP  = 2'd3;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAKE  = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_POLL  = 3'd3;
    localparam logic [2:0] PH_R7    = 3'd4;
    localparam logic [2:0] PH_TOKEN = 3'd5;
    localparam logic [2:0] PH_DATA  = 3'd6;

    localparam logic [5:0] CMD0  = 6'd0;
    localparam logic [5:0] CMD8  = 6'd8;
    localparam logic [5:0] CMD12 = 6'd12;
    localparam logic [5:0] CMD17 = 6'd17;
    localparam logic [5:0] CMD18 = 6'd18;
    localparam logic [5:0] CMD41 = 6'd41;
    localparam logic [5:0] CMD55 = 6'd55;
    localparam logic [5:0] CMD58 = 6'd58;

    localparam logic [0:0] CFG_POLL_LIMIT = 1'd0;
    localparam logic [0:0] CFG_RETRY      = 1'd1;

    localparam logic [7:0]  BYTE_IDLE  = 8'hff;
    localparam logic [7:0]  DATA_TOKEN = 8'hfe;
    localparam logic [7:0]  CRC_CMD8   = 8'h87;
    localparam logic [7:0]  CRC_CMD58  = 8'h75;
    localparam logic [7:0]  CRC_OTHER  = 8'h95;
    localparam logic [31:0] ARG_CMD8   = 32'h0000_01aa;
    localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;

endpackage

>>> rtl/core/sdsh_frame.sv
// ----------------------------------------------------------------------------
// sdsh_frame
// Picks the byte and chip-select level for one position of a command frame.
// ----------------------------------------------------------------------------
module sdsh_frame (
    input  logic [5:0]  cmd,
    input  logic [31:0] card_address,
    input  logic [3:0]  idx,
    output logic [7:0]  tx_byte,
    output logic        sel
);
    import sdsh_pkg::*;

    logic [31:0] arg;
    logic [3:0]  j;

    always_comb begin
        if (cmd == CMD8) arg = ARG_CMD8;
        else if (cmd == CMD41) arg = ARG_ACMD41;
        else if (cmd == CMD17 || cmd == CMD18) arg = card_address;
        else arg = '0;
        sel = 1'b0;
        j   = idx;
        if (cmd == CMD12) begin
            if (idx < 4'd2) sel = 1'b1;
            j = idx - 4'd2;
        end
        case (j)
            4'd1:    tx_byte = {2'b01, cmd};
            4'd2:    tx_byte = arg[31:24];
            4'd3:    tx_byte = arg[23:16];
            4'd4:    tx_byte = arg[15:8];
            4'd5:    tx_byte = arg[7:0];
            4'd6:    tx_byte = (cmd == CMD8) ? CRC_CMD8 :
                               (cmd == CMD58) ? CRC_CMD58 : CRC_OTHER;
            default: tx_byte = BYTE_IDLE;
        endcase
        if (sel) tx_byte = BYTE_IDLE;
    end
endmodule

>>> rtl/core/sd_spi_host_sequencer.sv
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// SD card SPI-mode init and block-read sequencer driving a byte shifter.
// ----------------------------------------------------------------------------
//  channel  | ports                    | carries
//  ---------+--------------------------+----------------------------------
//  input    | s_valid s_ready s_data   | start init / start read / rx byte
//  result   | m_valid m_ready m_data   | next tx byte, data byte, status
//  config   | cfg_valid cfg_ready      | cfg_index, cfg_data
//
// One transaction per cycle while s_ready is high: each input updates state in
// one pass and the result is registered in the output register. s_ready is high
// when the output register is empty or being drained, so a stream runs at full
// rate while the result side drains. A stalled output holds s_ready low. Reset
// (aresetn low, synchronous) returns to idle with limits 1000 and 20.
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer #(
    parameter int BLOCK_BYTES = 512,
    parameter int WAKE_BYTES  = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sdsh_pkg::sdsh_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sdsh_pkg::sdsh_out_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import sdsh_pkg::*;

    localparam int IW = (BLOCK_BYTES > WAKE_BYTES) ? $clog2(BLOCK_BYTES + 1)
                                                   : $clog2(WAKE_BYTES + 1);
    localparam int FW = (IW < 4) ? 4 : IW;

    logic [15:0]   limit_reg;
    logic [7:0]    budget_reg;
    logic [2:0]    phase_reg, phase_next;
    logic [FW-1:0] fidx_reg, fidx_next;
    logic [15:0]   poll_reg, poll_next;
    logic [7:0]    retry_reg, retry_next;
    logic [7:0]    blocks_reg, blocks_next;
    logic [31:0]   addr_reg, addr_next;
    logic          bam_reg, bam_next;
    logic [31:0]   reply_reg, reply_next;
    logic [5:0]    cmd_reg, cmd_next;
    logic          mv_reg;
    sdsh_out_t     out_reg, out_next;

    logic          fire, act, fin;
    logic [FW-1:0] fi1;
    logic [7:0]    rx, rl;
    logic [15:0]   lim;
    logic [7:0]    ftx;
    logic          fsel;

    assign s_ready   = !mv_reg || m_ready;
    assign fire      = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = mv_reg;
    assign m_data    = out_reg;
    assign rx        = s_data.rx_byte;
    assign lim       = (limit_reg == 16'd0) ? 16'd1 : limit_reg;
    assign fi1       = fidx_reg + 1'b1;

    sdsh_frame u_frame (
        .cmd          (cmd_next),
        .card_address (addr_next),
        .idx          (fidx_next[3:0]),
        .tx_byte      (ftx),
        .sel          (fsel)
    );

    always_comb begin
        phase_next  = phase_reg;
        fidx_next   = fidx_reg;
        poll_next   = poll_reg;
        retry_next  = retry_reg;
        blocks_next = blocks_reg;
        addr_next   = addr_reg;
        bam_next    = bam_reg;
        reply_next  = reply_reg;
        cmd_next    = cmd_reg;
        act         = 1'b0;
        fin         = 1'b0;
        rl          = (retry_reg != 8'd0) ? retry_reg - 8'd1 : 8'd0;
        out_next    = '0;
        if (s_data.kind == KIND_INIT || s_data.kind == KIND_READ) begin
            if (phase_reg != PH_IDLE) begin
                out_next.status = ST_BUSY;
            end else if (s_data.kind == KIND_INIT) begin
                phase_next = PH_WAKE;
                fidx_next  = '0;
                retry_next = budget_reg;
                act        = 1'b1;
            end else begin
                act         = 1'b1;
                blocks_next = s_data.block_count;
                addr_next   = bam_reg ? {s_data.sector[22:0], 9'd0} : s_data.sector;
                if (s_data.block_count == 8'd0) fin = 1'b1;
                else begin
                    cmd_next   = (s_data.block_count > 8'd1) ? CMD18 : CMD17;
                    phase_next = PH_CMD;
                    fidx_next  = '0;
                end
            end
        end else if (s_data.kind == KIND_XFER && phase_reg != PH_IDLE) begin
            act = 1'b1;
            unique case (phase_reg)
                PH_WAKE: begin
                    fidx_next = fi1;
                    if (fi1 >= FW'(WAKE_BYTES)) begin
                        cmd_next = CMD0; phase_next = PH_CMD; fidx_next = '0;
                    end
                end
                PH_CMD: begin
                    fidx_next = fi1;
                    if (fi1 >= ((cmd_reg == CMD12) ? FW'(10) : FW'(7))) begin
                        phase_next = PH_POLL; poll_next = '0;
                    end
                end
                PH_POLL: begin
                    poll_next = poll_reg + 16'd1;
                    if (rx != BYTE_IDLE || poll_next >= lim) begin
                        phase_next = PH_CMD;
                        fidx_next  = '0;
                        case (cmd_reg)
                            CMD0: begin
                                retry_next = rl;
                                cmd_next = (rx == 8'd1 || rl == 8'd0) ? CMD8 : CMD0;
                            end
                            CMD8: begin
                                retry_next = rl;
                                if (rx == 8'd1) begin
                                    phase_next = PH_R7; reply_next = '0;
                                end else cmd_next = (rl == 8'd0) ? CMD55 : CMD8;
                            end
                            CMD55: begin
                                if (rx == 8'd0) begin
                                    retry_next = rl; bam_next = 1'b1; cmd_next = CMD58;
                                end else cmd_next = CMD41;
                            end
                            CMD41: begin
                                retry_next = rl;
                                if (rx == 8'd0 || rl == 8'd0) begin
                                    bam_next = 1'b1; cmd_next = CMD58;
                                end else cmd_next = CMD55;
                            end
                            CMD58: begin
                                retry_next = rl;
                                if (rx == 8'd0) begin
                                    phase_next = PH_R7; reply_next = '0;
                                end else if (rl == 8'd0) begin
                                    phase_next = PH_IDLE; fin = 1'b1;
                                end
                            end
                            CMD17, CMD18: begin
                                if (rx == 8'd0) phase_next = PH_TOKEN;
                            end
                            default: begin
                                phase_next = PH_IDLE; fin = 1'b1;
                            end
                        endcase
                    end
                end
                PH_R7: begin
                    reply_next = {reply_reg[23:0], rx};
                    fidx_next  = fi1;
                    if (fi1 >= FW'(4)) begin
                        if (cmd_reg == CMD8) begin
                            cmd_next = CMD55; phase_next = PH_CMD; fidx_next = '0;
                        end else begin
                            if (reply_next[30]) bam_next = 1'b0;
                            phase_next = PH_IDLE; fin = 1'b1;
                        end
                    end
                end
                PH_TOKEN: begin
                    if (rx == DATA_TOKEN) begin
                        phase_next = PH_DATA; fidx_next = '0;
                    end
                end
                PH_DATA: begin
                    out_next.data_valid = 1'b1;
                    out_next.data_byte  = rx;
                    fidx_next = fi1;
                    if (fi1 >= FW'(BLOCK_BYTES)) begin
                        blocks_next = (blocks_reg != 8'd0) ? blocks_reg - 8'd1 : 8'd0;
                        if (blocks_next == 8'd0) begin
                            out_next.last = 1'b1;
                            if (cmd_reg == CMD18) begin
                                cmd_next = CMD12; phase_next = PH_CMD; fidx_next = '0;
                            end else begin
                                phase_next = PH_IDLE; fin = 1'b1;
                            end
                        end else phase_next = PH_TOKEN;
                    end
                end
                default: begin
                    phase_next = PH_IDLE; fin = 1'b1;
                end
            endcase
        end
        if (act && phase_next != PH_IDLE) begin
            out_next.exchange_request = 1'b1;
            out_next.tx_byte     = (phase_next == PH_CMD) ? ftx : BYTE_IDLE;
            out_next.select_high = (phase_next == PH_WAKE) ||
                                   (phase_next == PH_CMD && fsel);
        end
        if (fin) begin
            out_next.done_res = 1'b1;
            out_next.status   = ST_DONE;
        end
        out_next.block_addressing = !bam_next;
        if (s_data.kind == KIND_NOP || (s_data.kind == KIND_XFER && !act)) out_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= 16'd1000;
            budget_reg <= 8'd20;
            phase_reg  <= PH_IDLE;
            fidx_reg   <= '0;
            poll_reg   <= '0;
            retry_reg  <= '0;
            blocks_reg <= '0;
            addr_reg   <= '0;
            bam_reg    <= 1'b0;
            reply_reg  <= '0;
            cmd_reg    <= '0;
            mv_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_POLL_LIMIT) limit_reg <= cfg_data;
                else budget_reg <= cfg_data[7:0];
            end
            if (fire) begin
                phase_reg  <= phase_next;
                fidx_reg   <= fidx_next;
                poll_reg   <= poll_next;
                retry_reg  <= retry_next;
                blocks_reg <= blocks_next;
                addr_reg   <= addr_next;
                bam_reg    <= bam_next;
                reply_reg  <= reply_next;
                cmd_reg    <= cmd_next;
                mv_reg     <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) out_reg <= out_next;
    end

    // A stalled result must not be overwritten by a new transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken over a stalled result");
    // Data bytes only appear while a read transfers data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && out_next.data_valid |-> phase_reg == PH_DATA)
        else $error("data byte outside data phase");
    // A finished sequence always leaves the sequencer idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && fin |=> phase_reg == PH_IDLE)
        else $error("finish without returning to idle");
endmodule

>>> tb/sd_spi_host_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer_tb
// Self-checking bench: a directed table, then card-like random traffic.
// Every input transaction yields one result, predicted in-bench and compared
// field by field in order. Limits are rewritten at idle points between phases.
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer_tb;
    import sdsh_pkg::*;

    localparam int         BLOCK_BYTES  = 512;
    localparam int         WAKE_BYTES   = 10;
    localparam logic [7:0] CMD_START    = 8'h40;   // start + transmission bits
    localparam int         RANDOM_ITEMS = 1450;
    localparam int         STALL_LIMIT  = 1000;    // cycles without any transaction
    localparam int         DRAIN_CYCLES = 8;
    localparam int         LONG_HOLD_AT = 420;     // result count before long hold-off

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sdsh_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sdsh_out_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    sd_spi_host_sequencer #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .WAKE_BYTES  (WAKE_BYTES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sequencer shadow state (mirrors the block's registers)
    // ------------------------------------------------------------------
    logic [15:0] poll_limit;
    logic [7:0]  retry_budget;
    logic [2:0]  seq_phase;
    int          byte_pos;
    logic [15:0] polls;
    logic [7:0]  retries;
    logic [7:0]  blocks_todo;
    logic [31:0] card_addr;
    logic        byte_mode;
    logic [31:0] reply_acc;
    logic [5:0]  cur_cmd;

    sdsh_out_t   result_q[$];      // results still owed by the block
    int          failures = 0;
    int          results_seen = 0;

    function automatic void begin_cmd(logic [5:0] c);
        cur_cmd   = c;
        seq_phase = PH_CMD;
        byte_pos  = 0;
    endfunction

    function automatic void use_retry();
        if (retries != 8'd0) retries = retries - 8'd1;
    endfunction

    function automatic void begin_reply();
        seq_phase = PH_R7;
        byte_pos  = 0;
        reply_acc = '0;
    endfunction

    function automatic void go_ocr();
        byte_mode = 1'b1;
        begin_cmd(CMD58);
    endfunction

    // Byte at position pos of the current command frame; CMD12 carries two
    // deselected fill bytes up front.
    function automatic logic [7:0] frame_tx(int pos);
        int          j;
        logic [31:0] arg;
        j = pos;
        if (cur_cmd == CMD12) begin
            if (pos < 2) return BYTE_IDLE;
            j = pos - 2;
        end
        if (cur_cmd == CMD8) arg = ARG_CMD8;
        else if (cur_cmd == CMD41) arg = ARG_ACMD41;
        else if (cur_cmd == CMD17 || cur_cmd == CMD18) arg = card_addr;
        else arg = '0;
        case (j)
            0: return BYTE_IDLE;
            1: return CMD_START | {2'b00, cur_cmd};
            2, 3, 4, 5: return 8'(arg >> (8 * (5 - j)));
            6: begin
                if (cur_cmd == CMD8) return CRC_CMD8;
                if (cur_cmd == CMD58) return CRC_CMD58;
                return CRC_OTHER;
            end
            default: return BYTE_IDLE;
        endcase
    endfunction

    // Returns 1 when the response ends the whole sequence.
    function automatic bit take_response(logic [7:0] r);
        case (cur_cmd)
            CMD0: begin
                use_retry();
                if (r == 8'h01 || retries == 0) begin_cmd(CMD8); else begin_cmd(CMD0);
            end
            CMD8: begin
                use_retry();
                if (r == 8'h01) begin_reply();
                else if (retries == 0) begin_cmd(CMD55);
                else begin_cmd(CMD8);
            end
            CMD55: begin
                if (r == 8'h00) begin
                    use_retry();
                    go_ocr();
                end else begin
                    begin_cmd(CMD41);
                end
            end
            CMD41: begin
                use_retry();
                if (r == 8'h00 || retries == 0) go_ocr(); else begin_cmd(CMD55);
            end
            CMD58: begin
                use_retry();
                if (r == 8'h00) begin_reply();
                else if (retries == 0) begin
                    seq_phase = PH_IDLE;
                    return 1'b1;
                end else begin_cmd(CMD58);
            end
            CMD17, CMD18: begin
                if (r == 8'h00) seq_phase = PH_TOKEN; else begin_cmd(cur_cmd);
            end
            default: begin
                seq_phase = PH_IDLE;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic sdsh_out_t predict_step(sdsh_in_t it);
        sdsh_out_t   o;
        bit          fin;
        bit          act;
        logic [15:0] lim;
        o   = '0;
        fin = 1'b0;
        act = 1'b0;
        lim = (poll_limit == 16'd0) ? 16'd1 : poll_limit;
        if (it.kind == KIND_INIT || it.kind == KIND_READ) begin
            if (seq_phase != PH_IDLE) begin
                o.status = ST_BUSY;
            end else if (it.kind == KIND_INIT) begin
                seq_phase = PH_WAKE;
                byte_pos  = 0;
                retries   = retry_budget;
                act       = 1'b1;
            end else begin
                act         = 1'b1;
                blocks_todo = it.block_count;
                card_addr   = byte_mode ? (it.sector << 9) : it.sector;
                if (it.block_count == 8'd0) fin = 1'b1;
                else begin_cmd(it.block_count > 8'd1 ? CMD18 : CMD17);
            end
        end else if (it.kind == KIND_XFER && seq_phase != PH_IDLE) begin
            act = 1'b1;
            case (seq_phase)
                PH_WAKE: begin
                    byte_pos++;
                    if (byte_pos >= WAKE_BYTES) begin_cmd(CMD0);
                end
                PH_CMD: begin
                    byte_pos++;
                    if (byte_pos >= ((cur_cmd == CMD12) ? 10 : 7)) begin
                        seq_phase = PH_POLL;
                        polls     = '0;
                    end
                end
                PH_POLL: begin
                    polls = polls + 16'd1;
                    if (it.rx_byte != BYTE_IDLE || polls >= lim)
                        fin = take_response(it.rx_byte);
                end
                PH_R7: begin
                    reply_acc = {reply_acc[23:0], it.rx_byte};
                    byte_pos++;
                    if (byte_pos >= 4) begin
                        if (cur_cmd == CMD8) begin
                            begin_cmd(CMD55);
                        end else begin
                            // OCR CCS bit: card takes block addresses
                            if (reply_acc[30]) byte_mode = 1'b0;
                            seq_phase = PH_IDLE;
                            fin       = 1'b1;
                        end
                    end
                end
                PH_TOKEN: begin
                    if (it.rx_byte == DATA_TOKEN) begin
                        seq_phase = PH_DATA;
                        byte_pos  = 0;
                    end
                end
                PH_DATA: begin
                    o.data_valid = 1'b1;
                    o.data_byte  = it.rx_byte;
                    byte_pos++;
                    if (byte_pos >= BLOCK_BYTES) begin
                        if (blocks_todo != 8'd0) blocks_todo = blocks_todo - 8'd1;
                        if (blocks_todo == 8'd0) begin
                            o.last = 1'b1;
                            if (cur_cmd == CMD18) begin_cmd(CMD12);
                            else begin
                                seq_phase = PH_IDLE;
                                fin       = 1'b1;
                            end
                        end else begin
                            seq_phase = PH_TOKEN;
                        end
                    end
                end
                default: begin
                    seq_phase = PH_IDLE;
                    fin       = 1'b1;
                end
            endcase
        end
        if (act && seq_phase != PH_IDLE) begin
            o.exchange_request = 1'b1;
            o.select_high      = (seq_phase == PH_WAKE) ||
                                 (seq_phase == PH_CMD && cur_cmd == CMD12 && byte_pos < 2);
            o.tx_byte          = (seq_phase == PH_CMD) ? frame_tx(byte_pos) : BYTE_IDLE;
        end
        if (fin) o.status = ST_DONE;
        o.done_res         = fin;
        o.block_addressing = ~byte_mode;
        if (it.kind == KIND_NOP || (it.kind == KIND_XFER && !act)) o = '0;
        return o;
    endfunction

    // What a mostly well-behaved card would answer in the current phase.
    function automatic logic [7:0] card_byte();
        int r;
        r = $urandom_range(0, 99);
        case (seq_phase)
            PH_POLL: begin
                if (r < 15) return BYTE_IDLE;
                if (r < 22) return 8'($urandom_range(0, 255));
                case (cur_cmd)
                    CMD0, CMD8: return 8'h01;
                    CMD55: return (r < 30) ? 8'h00 : 8'h01;
                    CMD41: return (r < 45) ? 8'h01 : 8'h00;
                    CMD58, CMD17, CMD18: return 8'h00;
                    default: return 8'($urandom_range(0, 255));
                endcase
            end
            PH_TOKEN: return (r < 80) ? DATA_TOKEN : 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    bit no_gaps = 1'b0;

    task automatic send_item(sdsh_in_t it, bit typed, sdsh_out_t typed_res);
        int        gap;
        sdsh_out_t res;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        res = predict_step(it);
        result_q.push_back(typed ? typed_res : res);
    endtask

    // Hold off until every result is back, then wait a further drain period.
    task automatic drain();
        s_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_POLL_LIMIT) poll_limit = val;
        else retry_budget = val[7:0];
    endtask

    task automatic set_limits(logic [15:0] lim, logic [7:0] budget);
        write_reg(CFG_POLL_LIMIT, lim);
        write_reg(CFG_RETRY, {8'h00, budget});
        cfg_valid <= 1'b0;
    endtask

    function automatic sdsh_in_t mk(logic [1:0] k, logic [31:0] sec, logic [7:0] cnt,
                                    logic [7:0] rx);
        sdsh_in_t it;
        it.kind        = k;
        it.sector      = sec;
        it.block_count = cnt;
        it.rx_byte     = rx;
        return it;
    endfunction

    // Directed table
    sdsh_in_t  dir_in[$];
    bit        dir_typed[$];
    sdsh_out_t dir_res[$];

    task automatic add_row(sdsh_in_t it, bit typed, sdsh_out_t res);
        dir_in.push_back(it);
        dir_typed.push_back(typed);
        dir_res.push_back(res);
    endtask

    initial begin
        sdsh_in_t  it;
        sdsh_out_t zero_res;
        sdsh_out_t busy_res;
        sdsh_out_t done_res;
        sdsh_out_t wake_res;
        logic [7:0] pattern [10];
        int        r;
        int        n;

        poll_limit   = 16'd1000;
        retry_budget = 8'd20;
        seq_phase    = PH_IDLE;
        byte_pos     = 0;
        polls        = '0;
        retries      = '0;
        blocks_todo  = '0;
        card_addr    = '0;
        byte_mode    = 1'b0;
        reply_acc    = '0;
        cur_cmd      = '0;

        zero_res = '0;
        busy_res = '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_BUSY, 1'b1};
        done_res = '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, ST_DONE, 1'b1};
        wake_res = '{1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_NONE, 1'b1};
        pattern  = '{8'h00, 8'hff, 8'haa, 8'h55, 8'h01, 8'h80, 8'hfe, 8'h7f, 8'h0f, 8'hf0};

        // idle-state corners, busy rejects, then a full wake run and CMD0
        add_row(mk(KIND_XFER, 32'h0, 8'h00, 8'hff), 1'b1, zero_res);
        add_row(mk(KIND_NOP, 32'hffff_ffff, 8'hff, 8'hff), 1'b1, zero_res);
        add_row(mk(KIND_READ, 32'hffff_ffff, 8'h00, 8'h00), 1'b1, done_res);
        add_row(mk(KIND_INIT, 32'h0, 8'h01, 8'h00), 1'b1, wake_res);
        add_row(mk(KIND_INIT, 32'hffff_ffff, 8'hff, 8'hff), 1'b1, busy_res);
        add_row(mk(KIND_READ, 32'h0, 8'd128, 8'h00), 1'b1, busy_res);
        add_row(mk(KIND_NOP, 32'h0, 8'h00, 8'h00), 1'b1, zero_res);
        for (int i = 0; i < WAKE_BYTES; i++)
            add_row(mk(KIND_XFER, 32'h0, 8'h00, pattern[i]), 1'b0, zero_res);
        for (int i = 0; i < 7; i++)
            add_row(mk(KIND_XFER, 32'h0, 8'h00, BYTE_IDLE), 1'b0, zero_res);
        add_row(mk(KIND_XFER, 32'h0, 8'h00, 8'h01), 1'b0, zero_res);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_in[i]) send_item(dir_in[i], dir_typed[i], dir_res[i]);

        // Random part: card-like traffic with some noise, limits changed at
        // idle points (these also serve as the sender's full pause).
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (n == 0) begin
                drain();
                set_limits(16'd1000, 8'd20);
            end else if (n == 350) begin
                drain();
                set_limits(16'd2, 8'd1);
            end else if (n == 750) begin
                drain();
                set_limits(16'hffff, 8'd255);
            end else if (n == 1100) begin
                drain();
                set_limits(16'd1, 8'd3);
            end
            r = $urandom_range(0, 99);
            if (seq_phase == PH_IDLE) begin
                if (r < 35) it = mk(KIND_INIT, $urandom, 8'($urandom), 8'($urandom));
                else if (r < 45) it = mk(KIND_READ, $urandom, 8'd0, 8'($urandom));
                else if (r < 72) it = mk(KIND_READ, $urandom, 8'd1, 8'($urandom));
                else if (r < 80) it = mk(KIND_READ, $urandom, 8'd2, 8'($urandom));
                else if (r < 90) it = mk(KIND_XFER, $urandom, 8'($urandom), 8'($urandom));
                else it = mk(KIND_NOP, $urandom, 8'($urandom), 8'($urandom));
            end else begin
                if (r < 94) it = mk(KIND_XFER, $urandom, 8'($urandom), card_byte());
                else if (r < 97)
                    it = mk(2'($urandom_range(0, 1)), $urandom, 8'($urandom), 8'($urandom));
                else it = mk(KIND_NOP, $urandom, 8'($urandom), 8'($urandom));
            end
            send_item(it, 1'b0, zero_res);
        end
        s_valid <= 1'b0;

        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("sd_spi_host_sequencer_tb: PASS");
        end else begin
            $display("sd_spi_host_sequencer_tb: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per transaction, one long hold-off so the
    // output register fills and s_ready drops.
    // ------------------------------------------------------------------
    initial begin
        int wait_n;
        bit long_done;
        long_done = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            wait_n = $urandom_range(0, 5);
            if (results_seen % 150 > 120) wait_n = 0;   // stretches at full rate
            if (!long_done && results_seen >= LONG_HOLD_AT) begin
                wait_n    = 80;
                long_done = 1'b1;
            end
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        sdsh_out_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (result_q.size() == 0) begin
                $error("result transaction with nothing expected");
                failures++;
            end else begin
                e = result_q.pop_front();
                check_field("exchange_request", e.exchange_request, m_data.exchange_request);
                check_field("tx_byte", e.tx_byte, m_data.tx_byte);
                check_field("select_high", e.select_high, m_data.select_high);
                check_field("data_valid", e.data_valid, m_data.data_valid);
                check_field("data_byte", e.data_byte, m_data.data_byte);
                check_field("last", e.last, m_data.last);
                check_field("done_res", e.done_res, m_data.done_res);
                check_field("status", e.status, m_data.status);
                check_field("block_addressing", e.block_addressing,
                            m_data.block_addressing);
            end
        end
    end

    // Watchdog: any accepted transaction on any channel resets the count.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("sd_spi_host_sequencer_tb: FAIL");
            $finish;
        end
    end

endmodule
